@@ hdl/rmdr_pkg.sv @@
// Shared types and constants for the rational multiply/divide/reduce unit.
`default_nettype none

package rmdr_pkg;

    // Widths of the result fields.
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;

    // Operation codes.
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL_N  = 8'b0000_0010,
        ST_MUL_D  = 8'b0000_0100,
        ST_CHECK  = 8'b0000_1000,
        ST_GCD    = 8'b0001_0000,
        ST_DIV_N  = 8'b0010_0000,
        ST_DIV_D  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

endpackage : rmdr_pkg

`default_nettype wire

@@ hdl/rmdr_req_if.sv @@
// Request and response channel interfaces of the rational multiply/divide/reduce unit.
`default_nettype none

interface rmdr_req_if #(
    parameter int PART_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [PART_WIDTH-1:0] a_num;
    logic        [PART_WIDTH-2:0] a_den;
    logic signed [PART_WIDTH-1:0] b_num;
    logic        [PART_WIDTH-2:0] b_den;

    modport source (
        output valid, operation, a_num, a_den, b_num, b_den,
        input  ready
    );
    modport sink (
        input  valid, operation, a_num, a_den, b_num, b_den,
        output ready
    );
endinterface : rmdr_req_if

interface rmdr_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_num;
    logic        [30:0] res_den;
    logic               div_by_zero;

    modport source (
        output valid, res_num, res_den, div_by_zero,
        input  ready
    );
    modport sink (
        input  valid, res_num, res_den, div_by_zero,
        output ready
    );
endinterface : rmdr_rsp_if

`default_nettype wire

@@ hdl/rational_mul_div_reduce_unit.sv @@
// Rational multiply/divide with reduction to lowest terms, top level.
//
// The req channel carries one item: an operation (multiply or divide) and two
// fractions, each a signed numerator and an unsigned denominator. The rsp
// channel returns one item per request: the reduced fraction and an error
// flag. A divide by a zero fraction, a zero a_den or a multiply by a zero b_den
// returns 0/0 with div_by_zero set; a zero product numerator otherwise gives 0/1.
// Both channels use valid/ready; an item moves when both are high.
// One shared multiplier forms the numerator and then the denominator product. One
// shared subtractor then runs a binary GCD (a shift, subtract or swap per cycle)
// and two restoring divisions by the GCD, one quotient bit per cycle.
// An item passes from acceptance through ST_MUL_N, ST_MUL_D, ST_CHECK, ST_GCD,
// ST_DIV_N and ST_DIV_D to ST_FINISH, which loads the result register.
// Special cases skip the GCD and divisions, going from ST_CHECK to ST_FINISH.
// req.ready is high only while the sequencer is idle. The result sits in an
// output register, so a new item may be accepted while the last result waits;
// if the receiver still stalls when the next result is done, the sequencer
// holds in its final state until the output register frees.
// Reset is asynchronous and active low; it empties the output register and
// returns the sequencer to idle.
`default_nettype none

module rational_mul_div_reduce_unit #(
    parameter int PART_WIDTH = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rmdr_req_if.sink    req,
    rmdr_rsp_if.source  rsp
);
    import rmdr_pkg::*;

    localparam int MAG_W  = PART_WIDTH;
    localparam int PROD_W = 2 * PART_WIDTH - 1;
    localparam int SUB_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(PROD_W);

    state_t state_reg, state_next;

    // Latched operands.
    logic              op_reg;
    logic              neg_reg;
    logic [MAG_W-1:0]  an_reg, bn_reg;
    logic [MAG_W-1:0]  ad_reg, bd_reg;
    logic              err_reg, zero_reg;

    // Working registers.
    logic [PROD_W-1:0] n_reg, d_reg, n_next, d_next;
    logic [PROD_W-1:0] x_reg, y_reg, x_next, y_next;
    logic [PROD_W-1:0] g_reg, g_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              err_next, zero_next;

    // Output register.
    logic                        out_valid_reg;
    logic signed [RES_NUM_W-1:0] out_num_reg;
    logic        [RES_DEN_W-1:0] out_den_reg;
    logic                        out_err_reg;

    // Operand magnitudes.
    logic [MAG_W-1:0] an_mag, bn_mag;

    // Shared multiplier.
    logic [MAG_W-1:0]   mul_a, mul_b;
    logic [2*MAG_W-1:0] product;

    // Shared subtractor.
    logic [SUB_W-1:0] sub_a, sub_b;
    logic [SUB_W:0]   diff;
    logic             borrow;
    logic [SUB_W-1:0] shifted;
    logic [PROD_W-1:0] rem_step, quo_step;
    logic             cnt_last;

    // Result formatting.
    logic [63:0] num_wide, num_signed, den_wide;
    logic        out_free;

    assign an_mag = req.a_num[PART_WIDTH-1] ? MAG_W'(-req.a_num) : MAG_W'(req.a_num);
    assign bn_mag = req.b_num[PART_WIDTH-1] ? MAG_W'(-req.b_num) : MAG_W'(req.b_num);

    // The multiplier forms the numerator product first, then the denominator.
    always_comb
    begin
        if (state_reg == ST_MUL_N)
        begin
            mul_a = an_reg;
            mul_b = (op_reg == OP_DIV) ? bd_reg : bn_reg;
        end
        else
        begin
            mul_a = ad_reg;
            mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg;
        end
    end

    assign product = mul_a * mul_b;

    // The subtractor compares x and y during the GCD, and trial-subtracts the
    // GCD from the shifted partial remainder during the divisions.
    assign shifted = {x_reg, y_reg[PROD_W-1]};

    always_comb
    begin
        if (state_reg == ST_GCD)
        begin
            sub_a = {1'b0, x_reg};
            sub_b = {1'b0, y_reg};
        end
        else
        begin
            sub_a = shifted;
            sub_b = {1'b0, g_reg};
        end
    end

    assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow   = diff[SUB_W];
    assign rem_step = borrow ? shifted[PROD_W-1:0] : diff[PROD_W-1:0];
    assign quo_step = {y_reg[PROD_W-2:0], ~borrow};
    assign cnt_last = (cnt_reg == CNT_W'(PROD_W - 1));

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        g_next     = g_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N:
            begin
                n_next     = product[PROD_W-1:0];
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                d_next     = product[PROD_W-1:0];
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                err_next  = (d_reg == '0);
                zero_next = (n_reg == '0);
                x_next    = n_reg;
                y_next    = d_reg;
                if (d_reg == '0 || n_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                // Binary GCD; common factors of two are removed from n and d
                // directly, so the odd GCD divides what remains.
                priority if (x_reg == '0 || y_reg == '0)
                begin
                    g_next     = x_reg | y_reg;
                    x_next     = '0;
                    y_next     = n_reg;
                    cnt_next   = '0;
                    state_next = ST_DIV_N;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    n_next = n_reg >> 1;
                    d_next = d_reg >> 1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (!borrow)
                begin
                    x_next = diff[PROD_W-1:0];
                end
                else
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            ST_DIV_N:
            begin
                x_next   = rem_step;
                y_next   = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    n_next     = quo_step;
                    x_next     = '0;
                    y_next     = d_reg;
                    cnt_next   = '0;
                    state_next = ST_DIV_D;
                end
            end
            ST_DIV_D:
            begin
                x_next   = rem_step;
                y_next   = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign num_wide   = 64'(n_reg);
    assign num_signed = neg_reg ? -num_wide : num_wide;
    assign den_wide   = 64'(y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid)
        begin
            op_reg  <= req.operation;
            neg_reg <= req.a_num[PART_WIDTH-1] ^ req.b_num[PART_WIDTH-1];
            an_reg  <= an_mag;
            bn_reg  <= bn_mag;
            ad_reg  <= {1'b0, req.a_den};
            bd_reg  <= {1'b0, req.b_den};
        end
        n_reg    <= n_next;
        d_reg    <= d_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        g_reg    <= g_next;
        cnt_reg  <= cnt_next;
        err_reg  <= err_next;
        zero_reg <= zero_next;
        if (state_reg == ST_FINISH && out_free)
        begin
            priority if (err_reg)
            begin
                out_num_reg <= '0;
                out_den_reg <= '0;
                out_err_reg <= 1'b1;
            end
            else if (zero_reg)
            begin
                out_num_reg <= '0;
                out_den_reg <= RES_DEN_W'(1);
                out_err_reg <= 1'b0;
            end
            else
            begin
                out_num_reg <= num_signed[RES_NUM_W-1:0];
                out_den_reg <= den_wide[RES_DEN_W-1:0];
                out_err_reg <= 1'b0;
            end
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.res_num     = out_num_reg;
    assign rsp.res_den     = out_den_reg;
    assign rsp.div_by_zero = out_err_reg;

    // An error result is always 0/0.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.div_by_zero |-> rsp.res_num == '0 && rsp.res_den == '0)
        else $error("error result is not 0/0");

    // A result without error never has a zero denominator.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.div_by_zero |-> rsp.res_den != '0)
        else $error("zero denominator without error flag");

    // After an item is accepted the unit is busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted back to back");

    // The GCD never runs with both operands zero.
    a_gcd_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GCD |-> (x_reg != '0 || y_reg != '0))
        else $error("GCD operands both zero");

endmodule : rational_mul_div_reduce_unit

`default_nettype wire
